// ===== design/eastd_pkg.sv =====
package eastd_pkg;

    localparam int COMP_W            = 16;
    localparam int UNITY             = 32768;
    localparam int EDGE_TABLE_SIZE   = 256;
    localparam int EDGE_IDX_W        = 8;
    localparam int CNT_W             = 12;
    localparam int ROW_W             = 16;
    localparam int NUM_W             = 36;
    localparam int DEN_W             = 20;
    localparam int QUO_W             = 16;
    localparam int QCNT_W            = 5;
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int NB_CENTRE         = 4;
    localparam int NB_LAST           = 8;

    localparam logic [15:0] RST_SPATIAL  = 16'd16384;
    localparam logic [15:0] RST_TEMPORAL = 16'd16384;
    localparam logic [15:0] RST_THRESH   = 16'd26;
    localparam logic [15:0] RST_DETAIL   = 16'd0;
    localparam logic [15:0] RST_MOTION   = 16'd0;
    localparam logic [11:0] RST_WIDTH    = 12'd1920;
    localparam logic [15:0] RST_HEIGHT   = 16'd1080;
    localparam logic [1:0]  RST_MODE     = 2'd0;

    localparam logic [1:0] MODE_SPATIAL = 2'd0;
    localparam logic [1:0] MODE_PREV    = 2'd1;
    localparam logic [1:0] MODE_MOTION  = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        REG_SPATIAL,
        REG_TEMPORAL,
        REG_THRESH,
        REG_DETAIL,
        REG_MOTION,
        REG_WIDTH,
        REG_HEIGHT,
        REG_MODE
    } reg_index_t;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } pixel_t;

    typedef struct packed {
        pixel_t temp;
        pixel_t centre;
        pixel_t upper;
    } line_word_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] cur_red;
        logic [15:0] cur_green;
        logic [15:0] cur_blue;
        logic [15:0] cur_alpha;
        logic [15:0] prev_red;
        logic [15:0] prev_green;
        logic [15:0] prev_blue;
        logic [15:0] motion_confidence;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
        logic        end_of_frame;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [15:0] ss;
        logic [15:0] ts;
        logic [15:0] thr;
        logic [15:0] keep;
        logic [15:0] ms;
        logic [1:0]  mode;
    } filt_cfg_t;

    typedef struct packed {
        pixel_t [8:0] pix;
        pixel_t       tmp;
        logic         eof;
    } filt_job_t;

    typedef struct packed {
        logic idle;
        logic done;
    } filt_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_LAUNCH,
        T_WAIT
    } top_state_t;

    typedef enum logic [4:0] {
        F_IDLE,
        F_CLUMA,
        F_NB,
        F_EDIV,
        F_EWAIT,
        F_WGT,
        F_ACC,
        F_T0,
        F_T1,
        F_T2,
        F_ADIV,
        F_AWAIT,
        F_K0,
        F_K1,
        F_B0,
        F_B1,
        F_STORE,
        F_DONE
    } filt_state_t;

    typedef logic [EDGE_TABLE_SIZE-1:0][15:0] edge_table_t;

    // exp(-8 i / size) in Q1.15, from a truncated series for one step
    function automatic edge_table_t build_edge_table();
        edge_table_t     tbl;
        longint unsigned x;
        longint unsigned term;
        longint unsigned step;
        longint unsigned acc;
        x    = (64'd8 << 32) / EDGE_TABLE_SIZE;
        term = 64'd1 << 32;
        step = 64'd1 << 32;
        acc  = 64'd1 << 32;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * x) >> 32) / 64'(k);
            if (k[0]) step = step - term;
            else      step = step + term;
        end
        for (int i = 0; i < EDGE_TABLE_SIZE; i++) begin
            tbl[i] = 16'((acc + (64'd1 << 16)) >> 17);
            acc    = (acc * step + (64'd1 << 31)) >> 32;
        end
        return tbl;
    endfunction

    localparam edge_table_t EDGE_TABLE = build_edge_table();

    function automatic logic [15:0] gain(input logic [15:0] v);
        return (v > 16'(UNITY)) ? 16'(UNITY) : v;
    endfunction

    function automatic logic [15:0] luma(input pixel_t p);
        logic [33:0] s;
        s = 34'd13933 * 34'(p.red) + 34'd46871 * 34'(p.green)
          + 34'd4732 * 34'(p.blue) + 34'd32768;
        return s[31:16];
    endfunction

    function automatic logic [15:0] comp(input pixel_t p, input logic [1:0] ch);
        logic [15:0] r;
        case (ch)
            2'd0:    r = p.red;
            2'd1:    r = p.green;
            2'd2:    r = p.blue;
            default: r = p.alpha;
        endcase
        return r;
    endfunction

endpackage

// ===== design/edge_aware_spatiotemporal_denoise.sv =====
// Edge-aware 3x3 spatio-temporal denoiser. Pixels arrive in raster order with
// the previous-frame pixel at the same place; the result for pixel (x,y-1) leaves
// when pixel (x+1,y) arrives, so after the last row send frame_width drain ticks.
// One item is in work at a time. An item reads its column from the line memory
// and updates the window; each result it causes is then worked out by the shared
// restoring divider (one edge-table index per neighbour and one average per
// color) and the single 16x16 multiplier. Ignored items (a pixel while draining,
// a drain tick mid-frame) are taken without leaving the idle state. The line
// memory needs no clearing after reset. A finished result waits in the output
// register while the next item is taken.
module edge_aware_spatiotemporal_denoise
    import eastd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CNT_W-1:0] W_CAP =
        (MAX_WIDTH > 4095) ? {CNT_W{1'b1}} : CNT_W'(MAX_WIDTH);

    top_state_t state_reg, state_next;

    logic [15:0] ss_reg, ts_reg, thr_reg, keep_reg, ms_reg, fh_reg;
    logic [11:0] fw_reg;
    logic [1:0]  mode_reg;

    logic [CNT_W-1:0] col_reg, drain_cnt_reg, x_reg;
    logic [ROW_W-1:0] row_reg;
    logic             drain_reg;
    pixel_t           pix_reg, tmp_reg, hold_reg;
    pixel_t [8:0]     win_reg;
    logic             pend1_reg, pend2_reg;
    logic [1:0]       j1_l_reg, j2_l_reg;
    pixel_t           j1_tmp_reg, j2_tmp_reg;
    logic             j2_eof_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic [CNT_W-1:0] w_eff, x_c;
    logic [ROW_W-1:0] h_eff;
    logic             accept, live;
    line_word_t       rd_word, wr_word;
    pixel_t           mid, top, bot;
    logic             job_start, job_ack, take, out_pop;
    logic [1:0]       cols [3];
    filt_job_t        job;
    filt_cfg_t        fcfg;
    filt_status_t     filt_st;
    out_item_t        filt_res;

    assign w_eff  = (fw_reg == 12'd0) ? CNT_W'(1) : ((fw_reg > W_CAP) ? W_CAP : fw_reg);
    assign h_eff  = (fh_reg == 16'd0) ? 16'd1 : fh_reg;
    assign accept = in_valid && !in_stall;
    assign live   = (in_item.opcode == OP_PIXEL) ? (row_reg < h_eff) : (row_reg >= h_eff);

    always_comb
    begin
        if (in_item.opcode == OP_PIXEL)
        begin
            x_c = (col_reg < w_eff) ? col_reg : (w_eff - 1'b1);
        end
        else
        begin
            x_c = (drain_cnt_reg < w_eff) ? drain_cnt_reg : (w_eff - 1'b1);
        end
    end

    assign mid = rd_word.centre;
    assign top = (row_reg >= 16'd2) ? rd_word.upper : mid;
    assign bot = drain_reg ? mid : pix_reg;

    assign wr_word.temp   = tmp_reg;
    assign wr_word.centre = pix_reg;
    assign wr_word.upper  = mid;

    eastd_linebuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept && live),
        .rd_addr (AW'(x_c)),
        .rdata   (rd_word),
        .wr_en   ((state_reg == T_READ) && !drain_reg),
        .wr_addr (AW'(x_reg)),
        .wr_data (wr_word)
    );

    // column selection of the window for the pending request
    always_comb
    begin
        if (pend1_reg)
        begin
            cols[0] = j1_l_reg;
            cols[1] = 2'd1;
            cols[2] = 2'd2;
            job.tmp = j1_tmp_reg;
            job.eof = 1'b0;
        end
        else
        begin
            cols[0] = j2_l_reg;
            cols[1] = 2'd2;
            cols[2] = 2'd2;
            job.tmp = j2_tmp_reg;
            job.eof = j2_eof_reg;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case (cols[k])
                    2'd0:    job.pix[r*3+k] = win_reg[r*3];
                    2'd1:    job.pix[r*3+k] = win_reg[r*3+1];
                    default: job.pix[r*3+k] = win_reg[r*3+2];
                endcase
            end
        end
    end

    assign fcfg.ss   = ss_reg;
    assign fcfg.ts   = ts_reg;
    assign fcfg.thr  = thr_reg;
    assign fcfg.keep = keep_reg;
    assign fcfg.ms   = ms_reg;
    assign fcfg.mode = mode_reg;

    eastd_filter u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (fcfg),
        .start  (job_start),
        .job    (job),
        .ack    (job_ack),
        .status (filt_st),
        .result (filt_res)
    );

    assign out_pop = out_valid_reg && !out_stall;
    assign take    = filt_st.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:   if (accept && live) state_next = T_READ;
            T_READ:
            begin
                if ((row_reg >= 16'd1) && ((x_reg >= CNT_W'(1)) || (x_reg == w_eff - 1'b1)))
                begin
                    state_next = T_LAUNCH;
                end
                else
                begin
                    state_next = T_IDLE;
                end
            end
            T_LAUNCH: state_next = T_WAIT;
            T_WAIT:
            begin
                if (take)
                begin
                    state_next = (pend1_reg && pend2_reg) ? T_LAUNCH : T_IDLE;
                end
            end
            default:  state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != T_IDLE);
        job_start = (state_reg == T_LAUNCH);
        job_ack   = (state_reg == T_WAIT) && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            ss_reg        <= RST_SPATIAL;
            ts_reg        <= RST_TEMPORAL;
            thr_reg       <= RST_THRESH;
            keep_reg      <= RST_DETAIL;
            ms_reg        <= RST_MOTION;
            fw_reg        <= RST_WIDTH;
            fh_reg        <= RST_HEIGHT;
            mode_reg      <= RST_MODE;
            col_reg       <= '0;
            row_reg       <= '0;
            drain_cnt_reg <= '0;
            pend1_reg     <= 1'b0;
            pend2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (reg_index_t'(cfg_index))
                    REG_SPATIAL:  ss_reg   <= cfg_data;
                    REG_TEMPORAL: ts_reg   <= cfg_data;
                    REG_THRESH:   thr_reg  <= cfg_data;
                    REG_DETAIL:   keep_reg <= cfg_data;
                    REG_MOTION:   ms_reg   <= cfg_data;
                    REG_WIDTH:    fw_reg   <= cfg_data[11:0];
                    REG_HEIGHT:   fh_reg   <= cfg_data;
                    REG_MODE:     mode_reg <= cfg_data[1:0];
                    default:      mode_reg <= mode_reg;
                endcase
            end
            if (state_reg == T_READ)
            begin
                pend1_reg <= (row_reg >= 16'd1) && (x_reg >= CNT_W'(1));
                pend2_reg <= (row_reg >= 16'd1) && (x_reg == w_eff - 1'b1);
                if (!drain_reg)
                begin
                    if (x_reg == w_eff - 1'b1)
                    begin
                        col_reg       <= '0;
                        row_reg       <= row_reg + 1'b1;
                        drain_cnt_reg <= '0;
                    end
                    else
                    begin
                        col_reg <= x_reg + 1'b1;
                    end
                end
                else if (x_reg == w_eff - 1'b1)
                begin
                    // frame done: clear all counters
                    col_reg       <= '0;
                    row_reg       <= '0;
                    drain_cnt_reg <= '0;
                end
                else
                begin
                    drain_cnt_reg <= x_reg + 1'b1;
                end
            end
            else if (job_ack)
            begin
                if (pend1_reg) pend1_reg <= 1'b0;
                else           pend2_reg <= 1'b0;
            end
            if (job_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && live)
        begin
            x_reg     <= x_c;
            drain_reg <= (in_item.opcode == OP_DRAIN);
            pix_reg   <= {in_item.cur_alpha, in_item.cur_blue,
                          in_item.cur_green, in_item.cur_red};
            tmp_reg   <= {in_item.motion_confidence, in_item.prev_blue,
                          in_item.prev_green, in_item.prev_red};
        end
        if (state_reg == T_READ)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2]  <= top;
            win_reg[5]  <= mid;
            win_reg[8]  <= bot;
            j1_tmp_reg  <= hold_reg;
            j2_tmp_reg  <= rd_word.temp;
            hold_reg    <= rd_word.temp;
            j1_l_reg    <= (x_reg >= CNT_W'(2)) ? 2'd0 : 2'd1;
            j2_l_reg    <= (x_reg >= CNT_W'(1)) ? 2'd1 : 2'd2;
            j2_eof_reg  <= drain_reg;
        end
        if (job_ack)
        begin
            out_reg <= '{out_red:      filt_res.out_red,
                         out_green:    filt_res.out_green,
                         out_blue:     filt_res.out_blue,
                         out_alpha:    filt_res.out_alpha,
                         end_of_frame: filt_res.end_of_frame,
                         last_of_run:  !(pend1_reg && pend2_reg)};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(pend1_reg || pend2_reg))
        else $error("request taken while results still pending");

    a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_start |-> filt_st.idle)
        else $error("filter launched while busy");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.end_of_frame) |-> out_item.last_of_run)
        else $error("end of frame not on last result");

endmodule

// ===== design/eastd_linebuf.sv =====
module eastd_linebuf
    import eastd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH,
    parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output line_word_t    rdata,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  line_word_t    wr_data
);

    // upper row, centre row and previous-frame pixel share one word per column
    line_word_t mem [MAX_WIDTH];
    line_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/eastd_div.sv =====
module eastd_div
    import eastd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output div_status_t      status,
    output logic [QUO_W-1:0] quo
);

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [QUO_W-1:0]  q_reg, q_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // restoring division, one quotient bit a cycle; caller keeps num < den << QUO_W
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = NUM_W'(den) << (QUO_W - 1);
            q_next    = '0;
            cnt_next  = QCNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next   = {q_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[QUO_W-2:0], 1'b0};
            end
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quo         = q_reg;

endmodule

// ===== design/eastd_filter.sv =====
module eastd_filter
    import eastd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  filt_cfg_t    cfg,
    input  logic         start,
    input  filt_job_t    job,
    input  logic         ack,
    output filt_status_t status,
    output out_item_t    result
);

    filt_state_t state_reg, state_next;

    pixel_t [8:0] rot_reg;
    pixel_t       centre_reg;
    pixel_t       tmp_reg;
    logic         eof_reg;
    logic [15:0]  yc_reg;
    logic [15:0]  y_reg;
    logic [3:0]   nb_reg;
    logic [1:0]   ch_reg;
    logic [15:0]  e_reg;
    logic [15:0]  w_reg;
    logic [NUM_W-1:0] sum_reg [3];
    logic [DEN_W-1:0] wsum_reg;
    logic [15:0]  shape_reg;
    logic [15:0]  tc_reg;
    logic [15:0]  t_reg;
    logic [15:0]  v_reg;
    logic [31:0]  acc_reg;
    logic [15:0]  res_reg [3];

    logic [15:0]  mul_a, mul_b;
    logic [31:0]  prod;
    logic         div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    div_status_t  div_st;
    logic [QUO_W-1:0] div_quo;

    logic [15:0]  ss_g, ts_g, keep_g, ms_g, thr_eff;
    logic         temporal;
    logic [15:0]  diff;
    logic [32:0]  rnd15, rnd16, blend_sum;
    logic [17:0]  shape_c;
    logic [16:0]  tm;

    assign ss_g     = gain(cfg.ss);
    assign ts_g     = gain(cfg.ts);
    assign keep_g   = gain(cfg.keep);
    assign ms_g     = gain(cfg.ms);
    assign thr_eff  = (cfg.thr == 16'd0) ? 16'd1 : cfg.thr;
    assign temporal = (cfg.mode == MODE_PREV) || (cfg.mode == MODE_MOTION);
    assign diff     = (y_reg > yc_reg) ? (y_reg - yc_reg) : (yc_reg - y_reg);

    assign prod      = 32'(mul_a) * 32'(mul_b);
    assign rnd15     = 33'(prod) + 33'd16384;
    assign rnd16     = 33'(prod) + 33'd32768;
    assign blend_sum = 33'(acc_reg) + 33'(prod) + 33'd16384;
    assign shape_c   = 18'(UNITY) - 18'(ms_g) + 18'(rnd16[32:16]);
    assign tm        = rnd15[31:15];

    eastd_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_st),
        .quo    (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (start) state_next = F_CLUMA;
            F_CLUMA: state_next = F_NB;
            F_NB:    state_next = (nb_reg == 4'(NB_CENTRE)) ? F_ACC : F_EDIV;
            F_EDIV:  state_next = F_EWAIT;
            F_EWAIT: if (div_st.done) state_next = F_WGT;
            F_WGT:   state_next = F_ACC;
            F_ACC:
            begin
                if (ch_reg == 2'd2)
                begin
                    state_next = (nb_reg == 4'(NB_LAST)) ? F_T0 : F_NB;
                end
            end
            F_T0:    state_next = F_T1;
            F_T1:    state_next = F_T2;
            F_T2:    state_next = F_ADIV;
            F_ADIV:  state_next = F_AWAIT;
            F_AWAIT: if (div_st.done) state_next = F_K0;
            F_K0:    state_next = F_K1;
            F_K1:    state_next = temporal ? F_B0 : F_STORE;
            F_B0:    state_next = F_B1;
            F_B1:    state_next = F_STORE;
            F_STORE: state_next = (ch_reg == 2'd2) ? F_DONE : F_ADIV;
            F_DONE:  if (ack) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            F_EDIV:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(diff);
                div_den   = DEN_W'({thr_eff, 3'b000});
            end
            F_WGT:
            begin
                mul_a = e_reg;
                mul_b = ss_g;
            end
            F_ACC:
            begin
                mul_a = w_reg;
                mul_b = comp(rot_reg[0], ch_reg);
            end
            F_T0:
            begin
                mul_a = tmp_reg.alpha;
                mul_b = ms_g;
            end
            F_T1:
            begin
                mul_a = ts_g;
                mul_b = tmp_reg.alpha;
            end
            F_T2:
            begin
                mul_a = tc_reg;
                mul_b = shape_reg;
            end
            F_ADIV:
            begin
                div_start = 1'b1;
                div_num   = sum_reg[ch_reg] + NUM_W'(wsum_reg >> 1);
                div_den   = wsum_reg;
            end
            F_K0:
            begin
                mul_a = v_reg;
                mul_b = 16'(UNITY) - keep_g;
            end
            F_K1:
            begin
                mul_a = comp(centre_reg, ch_reg);
                mul_b = keep_g;
            end
            F_B0:
            begin
                mul_a = v_reg;
                mul_b = 16'(UNITY) - t_reg;
            end
            F_B1:
            begin
                mul_a = comp(tmp_reg, ch_reg);
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            nb_reg    <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                F_IDLE:
                begin
                    nb_reg <= '0;
                    ch_reg <= '0;
                end
                F_ACC:
                begin
                    if (ch_reg == 2'd2)
                    begin
                        ch_reg <= '0;
                        nb_reg <= nb_reg + 1'b1;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                F_STORE:
                begin
                    ch_reg <= (ch_reg == 2'd2) ? 2'd0 : (ch_reg + 1'b1);
                end
                default:
                begin
                    ch_reg <= ch_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    rot_reg    <= job.pix;
                    centre_reg <= job.pix[NB_CENTRE];
                    tmp_reg    <= job.tmp;
                    eof_reg    <= job.eof;
                    wsum_reg   <= '0;
                    for (int c = 0; c < 3; c++)
                    begin
                        sum_reg[c] <= '0;
                    end
                end
            end
            F_CLUMA: yc_reg <= luma(centre_reg);
            F_NB:
            begin
                if (nb_reg == 4'(NB_CENTRE)) w_reg <= 16'(UNITY);
                else                         y_reg <= luma(rot_reg[0]);
            end
            F_EWAIT:
            begin
                if (div_st.done)
                begin
                    // an index past the table end means no weight
                    e_reg <= (div_quo < QUO_W'(EDGE_TABLE_SIZE))
                           ? EDGE_TABLE[div_quo[EDGE_IDX_W-1:0]] : 16'd0;
                end
            end
            F_WGT: w_reg <= rnd15[30:15];
            F_ACC:
            begin
                sum_reg[ch_reg] <= sum_reg[ch_reg] + NUM_W'(prod);
                if (ch_reg == 2'd0)
                begin
                    wsum_reg <= wsum_reg + DEN_W'(w_reg);
                end
                if (ch_reg == 2'd2)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        rot_reg[i] <= rot_reg[i+1];
                    end
                    rot_reg[8] <= rot_reg[0];
                end
            end
            F_T0: shape_reg <= shape_c[15:0];
            F_T1: tc_reg    <= rnd16[31:16];
            F_T2:
            begin
                if (cfg.mode == MODE_MOTION)
                begin
                    t_reg <= (tm > 17'(UNITY)) ? 16'(UNITY) : tm[15:0];
                end
                else
                begin
                    t_reg <= ts_g;
                end
            end
            F_AWAIT: if (div_st.done) v_reg <= div_quo;
            F_K0:    acc_reg <= prod;
            F_K1:    v_reg   <= blend_sum[30:15];
            F_B0:    acc_reg <= prod;
            F_B1:    v_reg   <= blend_sum[30:15];
            F_STORE: res_reg[ch_reg] <= v_reg;
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.idle = (state_reg == F_IDLE);
    assign status.done = (state_reg == F_DONE);

    assign result.out_red      = res_reg[0];
    assign result.out_green    = res_reg[1];
    assign result.out_blue     = res_reg[2];
    assign result.out_alpha    = centre_reg.alpha;
    assign result.end_of_frame = eof_reg;
    assign result.last_of_run  = 1'b0;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == F_EWAIT || state_reg == F_AWAIT))
        else $error("quotient arrived outside a wait state");

endmodule

// ===== sim/tb.sv =====
module tb;
    import eastd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 2048;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    edge_aware_spatiotemporal_denoise u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the filter state
    logic [15:0] ss_reg, ts_reg, thr_reg, keep_reg, ms_reg, height_reg;
    logic [11:0] width_reg;
    logic [1:0]  mode_reg;
    logic [15:0] decay_tbl [EDGE_TABLE_SIZE];
    pixel_t      upper_mem [DEPTH];
    pixel_t      centre_mem [DEPTH];
    pixel_t      prev_mem [DEPTH];
    pixel_t      win [9];
    pixel_t      prev_hold;
    int unsigned col_cnt, row_cnt, drain_cnt;

    in_item_t    request_q [$];
    out_item_t   pixel_q [$];

    int unsigned send_idle, recv_idle;
    bit          hold_req;
    int unsigned hold_left;
    int unsigned errors, n_requests, n_results, n_frames;

    always #1 clk = ~clk;

    function automatic logic [15:0] sat_gain(logic [15:0] v);
        return (v > 16'd32768) ? 16'd32768 : v;
    endfunction

    function automatic longint unsigned chan(pixel_t p, int c);
        case (c)
            0:       return p.red;
            1:       return p.green;
            2:       return p.blue;
            default: return p.alpha;
        endcase
    endfunction

    function automatic longint unsigned luma_of(pixel_t p);
        return (64'd13933 * p.red + 64'd46871 * p.green + 64'd4732 * p.blue + 64'd32768) >> 16;
    endfunction

    function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
                                            longint unsigned g);
        return (a * (64'd32768 - g) + b * g + 64'd16384) >> 15;
    endfunction

    task automatic build_decay();
        longint unsigned x, term, stp, acc;
        x = (64'd8 << 32) / EDGE_TABLE_SIZE;
        term = 64'd1 << 32;
        stp = 64'd1 << 32;
        acc = 64'd1 << 32;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * x) >> 32) / k;
            if (k % 2 == 1)
                stp = stp - term;
            else
                stp = stp + term;
        end
        for (int i = 0; i < EDGE_TABLE_SIZE; i++)
        begin
            decay_tbl[i] = 16'((acc + (64'd1 << 16)) >> 17);
            acc = (acc * stp + (64'd1 << 31)) >> 32;
        end
    endtask

    function automatic out_item_t filter_pixel(int cl, int cc, int cr, pixel_t tmp, bit eof);
        out_item_t       res;
        pixel_t          centre, p;
        longint unsigned yc, yp, d, idx, e, w, thr, ss, keep, wsum, v, t;
        longint unsigned conf, ms, shape, tc;
        longint unsigned sum [3];
        int              cols [3];
        cols[0] = cl;
        cols[1] = cc;
        cols[2] = cr;
        centre = win[3 + cc];
        yc = luma_of(centre);
        thr = (thr_reg == 0) ? 1 : thr_reg;
        ss = sat_gain(ss_reg);
        keep = sat_gain(keep_reg);
        wsum = 0;
        for (int c = 0; c < 3; c++)
            sum[c] = 0;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                p = win[r * 3 + cols[k]];
                if (r == 1 && k == 1)
                    w = 32768;
                else
                begin
                    yp = luma_of(p);
                    d = (yp > yc) ? yp - yc : yc - yp;
                    idx = d * EDGE_TABLE_SIZE / (thr * 2048);
                    e = (idx < EDGE_TABLE_SIZE) ? decay_tbl[idx] : 0;
                    w = (e * ss + 16384) >> 15;
                end
                for (int c = 0; c < 3; c++)
                    sum[c] += w * chan(p, c);
                wsum += w;
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            v = (sum[c] + wsum / 2) / wsum;
            v = mix(v, chan(centre, c), keep);
            if (mode_reg == MODE_PREV || mode_reg == MODE_MOTION)
            begin
                t = sat_gain(ts_reg);
                if (mode_reg == MODE_MOTION)
                begin
                    conf = tmp.alpha;
                    ms = sat_gain(ms_reg);
                    shape = 32768 - ms + ((conf * ms + 32768) >> 16);
                    tc = (t * conf + 32768) >> 16;
                    t = (tc * shape + 16384) >> 15;
                    if (t > 32768)
                        t = 32768;
                end
                v = mix(v, chan(tmp, c), t);
            end
            if (v > 65535)
                v = 65535;
            case (c)
                0:       res.out_red = 16'(v);
                1:       res.out_green = 16'(v);
                default: res.out_blue = 16'(v);
            endcase
        end
        res.out_alpha = centre.alpha;
        res.end_of_frame = eof;
        res.last_of_run = 1'b0;
        return res;
    endfunction

    task automatic shift_column(int x, int y, bit drain, pixel_t pix, pixel_t tmp, int w);
        pixel_t    mid, top, bot, old;
        out_item_t res [2];
        int        n;
        n = 0;
        mid = centre_mem[x];
        top = (y >= 2) ? upper_mem[x] : mid;
        bot = drain ? mid : pix;
        old = prev_mem[x];
        if (!drain)
        begin
            upper_mem[x] = mid;
            centre_mem[x] = pix;
            prev_mem[x] = tmp;
        end
        for (int r = 0; r < 3; r++)
        begin
            win[r * 3] = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
        if (y >= 1)
        begin
            if (x >= 1)
            begin
                res[n] = filter_pixel((x >= 2) ? 0 : 1, 1, 2, prev_hold, 1'b0);
                n++;
            end
            if (x == w - 1)
            begin
                res[n] = filter_pixel((x >= 1) ? 1 : 2, 2, 2, old, drain);
                n++;
            end
            if (n > 0)
                res[n - 1].last_of_run = 1'b1;
            for (int i = 0; i < n; i++)
                pixel_q.push_back(res[i]);
        end
        prev_hold = old;
    endtask

    function automatic int eff_width();
        return (width_reg == 0) ? 1 : ((width_reg > DEPTH) ? DEPTH : width_reg);
    endfunction

    function automatic int eff_height();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    task automatic predict_request(in_item_t it);
        int     w, h, x;
        pixel_t pix, tmp;
        w = eff_width();
        h = eff_height();
        if (it.opcode == OP_PIXEL)
        begin
            if (row_cnt >= h)
                return;
            x = (col_cnt < w) ? col_cnt : w - 1;
            pix = '{alpha: it.cur_alpha, blue: it.cur_blue, green: it.cur_green, red: it.cur_red};
            tmp = '{alpha: it.motion_confidence, blue: it.prev_blue, green: it.prev_green,
                    red: it.prev_red};
            shift_column(x, row_cnt, 1'b0, pix, tmp, w);
            if (x == w - 1)
            begin
                col_cnt = 0;
                row_cnt++;
                drain_cnt = 0;
            end
            else
                col_cnt = x + 1;
        end
        else
        begin
            if (row_cnt < h)
                return;
            x = (drain_cnt < w) ? drain_cnt : w - 1;
            shift_column(x, row_cnt, 1'b1, '0, '0, w);
            if (x == w - 1)
            begin
                col_cnt = 0;
                row_cnt = 0;
                drain_cnt = 0;
            end
            else
                drain_cnt = x + 1;
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_request(in_item);
                void'(request_q.pop_front());
                n_requests++;
            end
            if (!(in_valid && in_stall))
            begin
                if (request_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_item <= request_q[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (out_item.end_of_frame)
                    n_frames++;
                if (pixel_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_item);
                end
                else
                begin
                    if (pixel_q[0] !== out_item)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h (r g b a eof last)",
                                 $time, pixel_q[0], out_item);
                    end
                    void'(pixel_q.pop_front());
                end
            end
            if (hold_req && hold_left == 0)
            begin
                hold_left = 3000;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_reg(reg_index_t idx, logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_SPATIAL:  ss_reg = v;
            REG_TEMPORAL: ts_reg = v;
            REG_THRESH:   thr_reg = v;
            REG_DETAIL:   keep_reg = v;
            REG_MOTION:   ms_reg = v;
            REG_WIDTH:    width_reg = v[11:0];
            REG_HEIGHT:   height_reg = v;
            default:      mode_reg = v[1:0];
        endcase
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || in_valid || pixel_q.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hffff;
            2:       return 16'($urandom);
            default: return 16'(32768 + $urandom_range(400) - 200);
        endcase
    endfunction

    function automatic in_item_t rand_pixel(logic op);
        in_item_t it;
        it.opcode = op;
        it.cur_red = rand_comp();
        it.cur_green = rand_comp();
        it.cur_blue = rand_comp();
        it.cur_alpha = 16'($urandom);
        it.prev_red = rand_comp();
        it.prev_green = rand_comp();
        it.prev_blue = rand_comp();
        it.motion_confidence = 16'($urandom);
        return it;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(4))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hffff;
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    // one full frame, with ignored drains mid-frame and ignored pixels while draining
    task automatic push_frame(output int cnt);
        int w, h;
        w = eff_width();
        h = eff_height();
        cnt = 0;
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                if ($urandom_range(99) < 5)
                    request_q.push_back(rand_pixel(OP_DRAIN));
                request_q.push_back(rand_pixel(OP_PIXEL));
                cnt++;
            end
        end
        for (int c = 0; c < w; c++)
        begin
            if ($urandom_range(99) < 8)
                request_q.push_back(rand_pixel(OP_PIXEL));
            request_q.push_back(rand_pixel(OP_DRAIN));
            cnt++;
        end
    endtask

    task automatic random_phase(int n_items, int s_idle, int r_idle, bit pressure);
        int got, cnt;
        write_reg(REG_SPATIAL, rand_gain());
        write_reg(REG_TEMPORAL, rand_gain());
        case ($urandom_range(3))
            0:       write_reg(REG_THRESH, 16'd0);
            1:       write_reg(REG_THRESH, 16'hffff);
            default: write_reg(REG_THRESH, 16'($urandom_range(1, 600)));
        endcase
        write_reg(REG_DETAIL, rand_gain());
        write_reg(REG_MOTION, rand_gain());
        write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? 12'd0 : 12'($urandom_range(1, 7)));
        write_reg(REG_HEIGHT, ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
        write_reg(REG_MODE, 16'($urandom_range(3)));
        @(posedge clk);
        cfg_we <= 1'b0;
        send_idle = s_idle;
        recv_idle = r_idle;
        hold_req = pressure;
        got = 0;
        while (got < n_items)
        begin
            push_frame(cnt);
            got += cnt;
        end
        wait_drained();
    endtask

    initial
    begin
        in_item_t it;
        int       cnt;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SPATIAL;
        cfg_data = '0;
        send_idle = 0;
        recv_idle = 0;
        hold_req = 0;
        hold_left = 0;
        errors = 0;
        n_requests = 0;
        n_results = 0;
        n_frames = 0;
        ss_reg = RST_SPATIAL;
        ts_reg = RST_TEMPORAL;
        thr_reg = RST_THRESH;
        keep_reg = RST_DETAIL;
        ms_reg = RST_MOTION;
        width_reg = RST_WIDTH;
        height_reg = RST_HEIGHT;
        mode_reg = RST_MODE;
        col_cnt = 0;
        row_cnt = 0;
        drain_cnt = 0;
        prev_hold = '0;
        for (int i = 0; i < 9; i++)
            win[i] = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            upper_mem[i] = '0;
            centre_mem[i] = '0;
            prev_mem[i] = '0;
        end
        build_decay();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: hard edges with the smallest threshold, full gains but no detail keep
        write_reg(REG_SPATIAL, 16'd32768);
        write_reg(REG_TEMPORAL, 16'd32768);
        write_reg(REG_THRESH, 16'd1);
        write_reg(REG_DETAIL, 16'd0);
        write_reg(REG_MOTION, 16'd32768);
        write_reg(REG_WIDTH, 12'd3);
        write_reg(REG_HEIGHT, 16'd2);
        write_reg(REG_MODE, 16'(MODE_MOTION));
        @(posedge clk);
        cfg_we <= 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            it = (i % 2 == 0) ? '0 : '1;
            it.opcode = OP_PIXEL;
            request_q.push_back(it);
            if (i == 2)
            begin
                it.opcode = OP_DRAIN;
                request_q.push_back(it);
            end
        end
        it = '1;
        it.opcode = OP_DRAIN;
        request_q.push_back(it);
        it.opcode = OP_PIXEL;
        request_q.push_back(it);
        it.opcode = OP_DRAIN;
        request_q.push_back(it);
        request_q.push_back(it);
        wait_drained();

        // single-pixel frames, two of them, in previous-frame mode
        write_reg(REG_WIDTH, 12'd1);
        write_reg(REG_HEIGHT, 16'd1);
        write_reg(REG_MODE, 16'(MODE_PREV));
        @(posedge clk);
        cfg_we <= 1'b0;
        push_frame(cnt);
        push_frame(cnt);
        wait_drained();

        random_phase(100, 0, 0, 1'b0);
        random_phase(100, 86, 0, 1'b0);
        random_phase(100, 0, 86, 1'b0);
        random_phase(100, 34, 34, 1'b0);
        random_phase(60, 0, 0, 1'b1);
        random_phase(100, 86, 0, 1'b0);
        random_phase(100, 0, 86, 1'b0);
        random_phase(60, 34, 34, 1'b0);

        $display("Covered %0d requests, %0d filtered pixels, %0d frames,", n_requests,
                 n_results, n_frames);
        $display("over all temporal modes, gain extremes and odd frame sizes.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== edge_aware_spatiotemporal_denoise.f =====
design/eastd_pkg.sv
design/eastd_linebuf.sv
design/eastd_div.sv
design/eastd_filter.sv
design/edge_aware_spatiotemporal_denoise.sv
sim/tb.sv
